// ----- sv/fnv1a_linear_probe_hash_table_macros.svh -----
// Assertion macros shared by the hash table checker.
// Depends on nothing; included by the checker file.
`ifndef FNV1A_LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define FNV1A_LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Asserts a property on the rising clock edge, disabled during reset.
`define FLPH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Asserts a property that must also hold during reset.
`define FLPH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- sv/flph_pkg.sv -----
// Package for the FNV-1a linear probing hash table: types, codes, constants.
// Depends on nothing; used by every module of the block.
package flph_pkg;

   localparam int SLOTS_DEFAULT      = 64;
   localparam int KEY_BYTES_DEFAULT  = 4;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_MULT  = 32'd16777619;

   localparam logic [1:0] FUNC_FIND   = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_SCAN   = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_ENTRY     = 3'd5;
   localparam logic [2:0] ST_SCAN_END  = 3'd6;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] lookup_key;
      logic [31:0] new_value;
      logic [5:0]  start_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_key;
      logic [31:0] found_value;
      logic [5:0]  slot;
   } rsp_type;

   // Control between the sequencer and the hash unit.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } hash_ctl_type;

endpackage

// ----- sv/flph_hasher.sv -----
// Iterative FNV-1a hash unit: one key byte folded in per cycle by a shared multiplier.
// Depends on flph_pkg.
module flph_hasher #(
   parameter int KEY_BYTES = 4,
   parameter int SLOT_BITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [8*KEY_BYTES-1:0]     key,
   output flph_pkg::hash_ctl_type     ctl,
   output logic [SLOT_BITS-1:0]       home
);
   import flph_pkg::*;

   localparam int CNT_BITS = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   logic [31:0]            hash_ff, hash_in;
   logic [8*KEY_BYTES-1:0] key_ff, key_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [31:0]            mixed;

   assign mixed = hash_ff ^ {24'd0, key_ff[7:0]};

   always_comb begin
      hash_in = hash_ff;
      key_in  = key_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hash_in = FNV_BASIS;
         key_in  = key;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hash_in = mixed * FNV_MULT;
         key_in  = key_ff >> 8;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(KEY_BYTES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      hash_ff <= hash_in;
      key_ff  <= key_in;
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;
   assign home      = hash_ff[SLOT_BITS-1:0];

endmodule

// ----- sv/fnv1a_linear_probe_hash_table.sv -----
// Open-addressed key/value table keyed by a 32-bit FNV-1a hash with linear probing.
// One request is worked at a time: the key is hashed one byte per cycle through a shared
// multiplier, then each probed slot takes a registered memory read and a compare; a scan
// reads and checks each slot in turn from start_slot. The occupancy bits are flip-flops
// cleared at reset, so no clearing pass is needed. A new key is refused with status full
// once SLOTS/2 entries are held. Depends on flph_pkg and flph_hasher.
module fnv1a_linear_probe_hash_table #(
   parameter int SLOTS      = flph_pkg::SLOTS_DEFAULT,
   parameter int KEY_BYTES  = flph_pkg::KEY_BYTES_DEFAULT,
   parameter int VALUE_BITS = flph_pkg::VALUE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  flph_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output flph_pkg::rsp_type rsp_data
);
   import flph_pkg::*;

   localparam int SB  = $clog2(SLOTS);
   localparam int KB  = 8 * KEY_BYTES;
   localparam int KW  = (KB < 32) ? KB : 32;
   localparam int VW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int CB  = SB + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_HASH, S_READ, S_CHECK, S_SCAN_RD, S_SCAN_CK, S_RESP
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   rsp_type   rsp_ff;
   logic [SB-1:0] addr_ff;
   logic [CB-1:0] tries_ff;
   logic [CB-1:0] count_ff;
   logic [SLOTS-1:0] occ_ff;

   logic [KW-1:0] key_mem [SLOTS];
   logic [VW-1:0] val_mem [SLOTS];
   logic [KW-1:0] rd_key_ff;
   logic [VW-1:0] rd_val_ff;
   logic          rd_occ_ff;

   logic          wr_en;
   logic [SB-1:0] wr_addr;
   logic          wr_key_en;
   logic [KW-1:0] req_key;
   logic [VW-1:0] req_val;

   hash_ctl_type  hctl;
   logic [SB-1:0] home;

   assign req_key = req_ff.lookup_key[KW-1:0];
   assign req_val = req_ff.new_value[VW-1:0];

   flph_hasher #(.KEY_BYTES(KEY_BYTES), .SLOT_BITS(SB)) u_hasher (
      .clock (clock),
      .reset (reset),
      .start (req_valid && req_ready && req_data.func != FUNC_SCAN),
      .key   (KB'(req_data.lookup_key)),
      .ctl   (hctl),
      .home  (home)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem[wr_addr] <= req_val;
         if (wr_key_en) begin
            key_mem[wr_addr] <= req_key;
         end
      end
      rd_key_ff <= key_mem[addr_ff];
      rd_val_ff <= val_mem[addr_ff];
      rd_occ_ff <= occ_ff[addr_ff];
   end

   function automatic rsp_type mk(logic [2:0] st, logic [KW-1:0] k,
                                  logic [VW-1:0] v, logic [SB-1:0] s);
      rsp_type r;
      r.status      = st;
      r.found_key   = 32'(k);
      r.found_value = 32'(v);
      r.slot        = 6'(s);
      return r;
   endfunction

   always_comb begin
      wr_en     = 1'b0;
      wr_key_en = 1'b0;
      wr_addr   = addr_ff;
      if (state_ff == S_CHECK && req_ff.func == FUNC_INSERT) begin
         if (rd_occ_ff && rd_key_ff == req_key) begin
            wr_en = 1'b1;
         end else if (!rd_occ_ff && count_ff < CB'(SLOTS / 2)) begin
            wr_en     = 1'b1;
            wr_key_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  if (req_data.func == FUNC_SCAN) begin
                     if (32'(req_data.start_slot) >= SLOTS) begin
                        rsp_ff   <= mk(ST_SCAN_END, '0, '0, '0);
                        state_ff <= S_RESP;
                     end else begin
                        addr_ff  <= SB'(req_data.start_slot);
                        state_ff <= S_SCAN_RD;
                     end
                  end else begin
                     state_ff <= S_HASH;
                  end
               end
            end
            S_HASH: begin
               if (hctl.done) begin
                  addr_ff  <= home;
                  tries_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               if (req_ff.func != FUNC_FIND && req_ff.func != FUNC_INSERT) begin
                  rsp_ff   <= mk(ST_NOT_FOUND, '0, '0, '0);
                  state_ff <= S_RESP;
               end else if (!rd_occ_ff) begin
                  if (req_ff.func == FUNC_FIND) begin
                     rsp_ff <= mk(ST_NOT_FOUND, '0, '0, '0);
                  end else if (count_ff >= CB'(SLOTS / 2)) begin
                     rsp_ff <= mk(ST_FULL, '0, '0, '0);
                  end else begin
                     rsp_ff   <= mk(ST_INSERTED, req_key, req_val, addr_ff);
                     occ_ff[addr_ff] <= 1'b1;
                     count_ff <= count_ff + 1'b1;
                  end
                  state_ff <= S_RESP;
               end else if (rd_key_ff == req_key) begin
                  if (req_ff.func == FUNC_FIND) begin
                     rsp_ff <= mk(ST_FOUND, rd_key_ff, rd_val_ff, addr_ff);
                  end else begin
                     rsp_ff <= mk(ST_UPDATED, req_key, req_val, addr_ff);
                  end
                  state_ff <= S_RESP;
               end else if (tries_ff == CB'(SLOTS - 1)) begin
                  rsp_ff   <= mk((req_ff.func == FUNC_FIND) ? ST_NOT_FOUND : ST_FULL,
                                 '0, '0, '0);
                  state_ff <= S_RESP;
               end else begin
                  tries_ff <= tries_ff + 1'b1;
                  addr_ff  <= addr_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CK;
            S_SCAN_CK: begin
               if (rd_occ_ff) begin
                  rsp_ff   <= mk(ST_ENTRY, rd_key_ff, rd_val_ff, addr_ff);
                  state_ff <= S_RESP;
               end else if (addr_ff == SB'(SLOTS - 1)) begin
                  rsp_ff   <= mk(ST_SCAN_END, '0, '0, '0);
                  state_ff <= S_RESP;
               end else begin
                  addr_ff  <= addr_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/flph_checker.sv -----
// Port-level checker for the hash table, bound to the top level.
// Depends on flph_pkg and the macros header.
`include "fnv1a_linear_probe_hash_table_macros.svh"

module flph_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input flph_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input flph_pkg::rsp_type rsp_data
);
   import flph_pkg::*;

   `FLPH_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
   `FLPH_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "second request taken while one is in work")
   `FLPH_ASSERT(a_not_both, !(req_ready && rsp_valid), "ready for a request while a response waits")
   `FLPH_ASSERT(a_empty_fields, rsp_valid && (rsp_data.status == ST_NOT_FOUND || rsp_data.status == ST_FULL || rsp_data.status == ST_SCAN_END) |-> rsp_data.found_key == 32'd0 && rsp_data.found_value == 32'd0 && rsp_data.slot == 6'd0, "empty result carries data")
   `FLPH_ASSERT_ALWAYS(a_reset_idle, $past(reset) |-> !rsp_valid, "response shown right after reset")

endmodule

bind fnv1a_linear_probe_hash_table flph_checker u_flph_checker (.*);
